// ===== hw/rtl/s3g_pkg.sv =====
// ----------------------------------------------------------------------------
// s3g_pkg: shared types and constants of the 3x3 Sobel gradient unit
// Sizes, register indexes, command codes and the queued item format.
// ----------------------------------------------------------------------------
package s3g_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int POS_W      = 13;
  localparam logic [POS_W-1:0] ROW_SAT = {POS_W{1'b1}};

  localparam int PIX_W      = 8;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int GRAD_W     = 11;

  localparam int FW_W       = 11;
  localparam int FH_W       = 12;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 1;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One classified beat for the back end
  typedef struct packed {
    logic             emit;
    logic [PIX_W-1:0] val;
    logic [COL_W-1:0] col;
    logic             first;
    logic             top;
    logic             bot;
    logic             left;
    logic             right;
    logic             fend;
  } s3g_item_t;

endpackage

// ===== hw/rtl/s3g_front.sv =====
// ----------------------------------------------------------------------------
// s3g_front: input classifier
// Holds the frame registers and the input and output positions, drops early
// flush beats, zeroes drain pixels and tags each beat with its border masks.
// ----------------------------------------------------------------------------
module s3g_front
  import s3g_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 take_i,
  input  logic                 cmd_i,
  input  logic [PIX_W-1:0]     pixel_i,
  output logic                 push_o,
  output s3g_item_t            item_o
);

  logic [FW_W-1:0]  fw_q;
  logic [FH_W-1:0]  fh_q;
  logic [COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [POS_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;

  logic [POS_W-1:0] fw_ext, eff_w, eff_h;
  logic [POS_W-1:0] in_col_nx, out_col_nx, out_row_nx;
  logic             drain, act, rdy, in_last, out_right, out_bot, fend;

  always_comb begin
    fw_ext = POS_W'(fw_q);
    if (fw_q == '0) begin
      eff_w = POS_W'(1);
    end else if (fw_ext > POS_W'(MAX_WIDTH)) begin
      eff_w = POS_W'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    eff_h = (fh_q == '0) ? POS_W'(1) : POS_W'(fh_q);

    drain      = in_row_q >= eff_h;
    act        = take_i && !(cmd_i == CMD_FLUSH && !drain);
    rdy        = (in_row_q >= POS_W'(2)) || (in_row_q == POS_W'(1) && in_col_q != '0);
    in_col_nx  = POS_W'(in_col_q) + POS_W'(1);
    in_last    = in_col_nx >= eff_w;
    out_col_nx = POS_W'(out_col_q) + POS_W'(1);
    out_row_nx = out_row_q + POS_W'(1);
    out_right  = out_col_nx >= eff_w;
    out_bot    = out_row_nx >= eff_h;
    fend       = out_right && out_bot;

    item_o.emit  = rdy;
    item_o.val   = drain ? '0 : pixel_i;
    item_o.col   = in_col_q;
    item_o.first = in_col_q == '0;
    item_o.top   = out_row_q == '0;
    item_o.bot   = out_bot;
    item_o.left  = out_col_q == '0;
    item_o.right = out_right;
    item_o.fend  = fend;
    push_o       = act;

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (act) begin
      if (in_last) begin
        in_col_d = '0;
        if (in_row_q != ROW_SAT) begin
          in_row_d = in_row_q + POS_W'(1);
        end
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
      if (rdy) begin
        if (fend) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (out_right) begin
          out_col_d = '0;
          out_row_d = out_row_nx;
        end else begin
          out_col_d = out_col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= FW_RESET;
      fh_q      <= FH_RESET;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FRAME_WIDTH: begin
            fw_q <= cfg_wdata_i[FW_W-1:0];
          end
          CFG_FRAME_HEIGHT: begin
            fh_q <= cfg_wdata_i[FH_W-1:0];
          end
        endcase
      end
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

// ===== hw/rtl/s3g_fifo.sv =====
// ----------------------------------------------------------------------------
// s3g_fifo: short item queue
// Decouples the classifier from the line store and gradient pipeline.
// ----------------------------------------------------------------------------
module s3g_fifo
  import s3g_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  s3g_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output s3g_item_t item_o
);

  s3g_item_t             slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  always_comb begin
    full_o  = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
    valid_o = cnt_q != '0;
    item_o  = slot_q[rd_q];
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;
    wr_d    = do_push ? wr_q + FIFO_PTR_W'(1) : wr_q;
    rd_d    = do_pop  ? rd_q + FIFO_PTR_W'(1) : rd_q;
    cnt_d   = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== hw/rtl/s3g_back.sv =====
// ----------------------------------------------------------------------------
// s3g_back: line stores, window and gradient
// Reads the two line stores as one 16-bit wide memory, shifts the 3x3 window,
// applies the border masks and registers the Sobel gradients.
// ----------------------------------------------------------------------------
module s3g_back
  import s3g_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     head_valid_i,
  input  s3g_item_t                head_i,
  output logic                     pop_o,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic signed [GRAD_W-1:0] grad_x_o,
  output logic signed [GRAD_W-1:0] grad_y_o,
  output logic                     frame_end_o
);

  logic [LINE_W-1:0] mem [MAX_WIDTH];
  logic [LINE_W-1:0] rd_q, fwd_data_q, line, wdata;
  logic              fwd_q;

  s3g_item_t         s1_q;
  logic              s1_valid_q;

  logic [PIX_W-1:0]  win_q [3][3];
  logic [PIX_W-1:0]  win_d [3][3];
  logic [PIX_W-1:0]  v     [3][3];
  logic [PIX_W-1:0]  newcol [3];

  logic              en, load;
  logic [GRAD_W-1:0] e [3][3];
  logic [GRAD_W-1:0] dx0, dx1, dx2, dy0, dy1, dy2, gx, gy;

  logic              out_valid_q;
  logic [GRAD_W-1:0] gx_q, gy_q;
  logic              fend_q;

  always_comb begin
    en    = !out_valid_q || !out_stall_i;
    pop_o = en && head_valid_i;
    load  = en && s1_valid_q;

    line   = fwd_q ? fwd_data_q : rd_q;
    wdata  = {line[PIX_W-1:0], s1_q.val};
    newcol[0] = line[LINE_W-1:PIX_W];
    newcol[1] = line[PIX_W-1:0];
    newcol[2] = s1_q.val;

    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
      win_d[r][2] = newcol[r];
    end

    // first column: centre is the column shifted in last, right is outside
    for (int r = 0; r < 3; r++) begin
      if (s1_q.first) begin
        v[r][0] = win_q[r][1];
        v[r][1] = win_q[r][2];
        v[r][2] = '0;
      end else begin
        v[r][0] = win_d[r][0];
        v[r][1] = win_d[r][1];
        v[r][2] = win_d[r][2];
      end
    end

    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && s1_q.top) || (r == 2 && s1_q.bot) ||
            (c == 0 && s1_q.left) || (c == 2 && s1_q.right)) begin
          e[r][c] = '0;
        end else begin
          e[r][c] = GRAD_W'(v[r][c]);
        end
      end
    end

    dx0 = e[0][2] - e[0][0];
    dx1 = e[1][2] - e[1][0];
    dx2 = e[2][2] - e[2][0];
    dy0 = e[2][0] - e[0][0];
    dy1 = e[2][1] - e[0][1];
    dy2 = e[2][2] - e[0][2];
    gx  = dx0 + {dx1[GRAD_W-2:0], 1'b0} + dx2;
    gy  = dy0 + {dy1[GRAD_W-2:0], 1'b0} + dy2;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q <= mem[head_i.col];
      if (s1_valid_q) begin
        mem[s1_q.col] <= wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q       <= head_i;
      fwd_data_q <= wdata;
    end
    if (load && s1_q.emit) begin
      gx_q   <= gx;
      gy_q   <= gy;
      fend_q <= s1_q.fend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      if (en) begin
        s1_valid_q  <= head_valid_i;
        fwd_q       <= s1_valid_q && (s1_q.col == head_i.col);
        out_valid_q <= s1_valid_q && s1_q.emit;
      end
      if (load) begin
        win_q <= win_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign grad_x_o    = gx_q;
  assign grad_y_o    = gy_q;
  assign frame_end_o = fend_q;

endmodule

// ===== hw/rtl/sobel_3x3_gradient.sv =====
// ----------------------------------------------------------------------------
// sobel_3x3_gradient: streaming 3x3 Sobel gradient unit
// Raster pixels in, signed horizontal and vertical gradients out, each result
// one row and one column behind its pixel; flush beats drain the frame.
//
//   channel | direction | handshake            | payload
//   in      | sink      | in_valid_i/in_stall_o | cmd_i, pixel_i
//   out     | source    | out_valid_o/out_stall_i | grad_x_o, grad_y_o, frame_end_o
//   cfg     | sink      | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// One beat per cycle sustained while in_stall_o is low; the result of a beat
// passes through the queue, the registered line store read and the
// output register. Reset clears positions and window and restores 640x480;
// line stores are not cleared. An output stall while a result is held freezes
// the back end and the queue absorbs up to four more beats before in_stall_o rises.
// ----------------------------------------------------------------------------
module sobel_3x3_gradient
  import s3g_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     cmd_i,
  input  logic [PIX_W-1:0]         pixel_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [GRAD_W-1:0] grad_x_o,
  output logic signed [GRAD_W-1:0] grad_y_o,
  output logic                     frame_end_o
);

  logic      take, push, full, pop, head_valid;
  s3g_item_t item, head;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  s3g_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .cmd_i       (cmd_i),
    .pixel_i     (pixel_i),
    .push_o      (push),
    .item_o      (item)
  );

  s3g_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head)
  );

  s3g_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .grad_x_o     (grad_x_o),
    .grad_y_o     (grad_y_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the streaming 3x3 Sobel gradient unit
// Frames of pixels go in through a queue-fed driver. A beat-level predictor
// of the line stores and window works out each expected gradient beat, and
// the monitor checks every output beat against the oldest of them.
// Short directed frames come first, then random frames of random size and
// one tall narrow frame with a pause midway under random idling on both
// sides, then more random frames with no idling.
// ----------------------------------------------------------------------------
module tb;
  import s3g_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT    = 600_000;
  localparam int SETTLE_TICKS = 10;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pix;
  } beat_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     fend;
  } grad_t;

  logic                     clk_i;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i   = CFG_FRAME_WIDTH;
  logic [CFG_W-1:0]         cfg_wdata_i = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic                     cmd_i       = CMD_PIXEL;
  logic [PIX_W-1:0]         pixel_i     = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [GRAD_W-1:0] grad_x_o;
  logic signed [GRAD_W-1:0] grad_y_o;
  logic                     frame_end_o;

  sobel_3x3_gradient uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .grad_x_o    (grad_x_o),
    .grad_y_o    (grad_y_o),
    .frame_end_o (frame_end_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // predictor state
  logic [FW_W-1:0]  fw_reg = FW_RESET;
  logic [FH_W-1:0]  fh_reg = FH_RESET;
  logic [PIX_W-1:0] line_up2 [MAX_WIDTH];
  logic [PIX_W-1:0] line_up1 [MAX_WIDTH];
  logic [PIX_W-1:0] win [3][3];
  int unsigned      col_in, row_in, col_out, row_out;

  beat_t       pixel_beats [$];
  grad_t       grad_expected [$];
  int unsigned beats_pushed = 0;
  int unsigned beats_taken  = 0;
  int unsigned counted      = 0;
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count  = 0;
  int          tx_idle_pct  = 0;
  int          rx_idle_pct  = 0;
  logic        settle       = 1'b0;
  logic        in_taken     = 1'b0;

  function automatic int unsigned eff_width(input logic [FW_W-1:0] fw);
    return (fw == 0) ? 1 : ((fw > MAX_WIDTH) ? MAX_WIDTH : fw);
  endfunction

  function automatic int unsigned eff_height(input logic [FH_W-1:0] fh);
    return (fh == 0) ? 1 : fh;
  endfunction

  task automatic sobel_advance(input logic cmd, input logic [PIX_W-1:0] pix);
    int unsigned      w, h, idx;
    bit               drain, ready, fend;
    logic [PIX_W-1:0] val;
    int               v [3][3];
    int               gx, gy;
    grad_t            g;
    w     = eff_width(fw_reg);
    h     = eff_height(fh_reg);
    drain = row_in >= h;
    if (cmd == CMD_FLUSH && !drain) return;
    val   = drain ? '0 : pix;
    ready = row_in >= 2 || (row_in == 1 && col_in >= 1);
    // row start: centre is the column shifted in last, right side is outside
    if (col_in == 0) begin
      for (int r = 0; r < 3; r++) begin
        v[r][0] = win[r][1];
        v[r][1] = win[r][2];
        v[r][2] = 0;
      end
    end
    idx = (col_in < MAX_WIDTH) ? col_in : MAX_WIDTH - 1;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = line_up2[idx];
    win[1][2] = line_up1[idx];
    win[2][2] = val;
    line_up2[idx] = line_up1[idx];
    line_up1[idx] = val;
    if (col_in != 0) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          v[r][c] = win[r][c];
    end
    if (col_in + 1 >= w) begin
      col_in = 0;
      if (row_in < ROW_SAT) row_in++;
    end else begin
      col_in++;
    end
    if (!ready) return;
    for (int k = 0; k < 3; k++) begin
      if (row_out == 0) v[0][k] = 0;
      if (row_out + 1 >= h) v[2][k] = 0;
      if (col_out == 0) v[k][0] = 0;
      if (col_out + 1 >= w) v[k][2] = 0;
    end
    gx = (v[0][2] - v[0][0]) + 2 * (v[1][2] - v[1][0]) + (v[2][2] - v[2][0]);
    gy = (v[2][0] - v[0][0]) + 2 * (v[2][1] - v[0][1]) + (v[2][2] - v[0][2]);
    fend   = row_out + 1 >= h && col_out + 1 >= w;
    g.gx   = gx[GRAD_W-1:0];
    g.gy   = gy[GRAD_W-1:0];
    g.fend = fend;
    grad_expected.push_back(g);
    if (fend) begin
      col_in  = 0;
      row_in  = 0;
      col_out = 0;
      row_out = 0;
    end else if (col_out + 1 >= w) begin
      col_out = 0;
      row_out++;
    end else begin
      col_out++;
    end
  endtask

  // output check first: a result always belongs to an earlier beat
  always @(posedge clk_i) begin : check_side
    grad_t want;
    cycle_count++;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (grad_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: result %0d unexpected: gx %0d gy %0d end %0b",
                   results_seen, grad_x_o, grad_y_o, frame_end_o);
      end else begin
        want = grad_expected.pop_front();
        if (grad_x_o !== want.gx || grad_y_o !== want.gy || frame_end_o !== want.fend) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: result %0d mismatch: want gx %0d gy %0d end %0b, got gx %0d gy %0d end %0b",
                     results_seen, want.gx, want.gy, want.fend,
                     grad_x_o, grad_y_o, frame_end_o);
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      beats_taken++;
      sobel_advance(cmd_i, pixel_i);
    end
  end

  always @(negedge clk_i) begin : drive_side
    beat_t nxt;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pixel_beats.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        nxt = pixel_beats.pop_front();
        in_valid_i <= 1'b1;
        cmd_i      <= nxt.cmd;
        pixel_i    <= nxt.pix;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && !settle && ($urandom_range(0, 99) < rx_idle_pct);
  end

  task automatic push_beat(input logic cmd, input logic [PIX_W-1:0] pix);
    beat_t b;
    b.cmd = cmd;
    b.pix = pix;
    pixel_beats.push_back(b);
    beats_pushed++;
  endtask

  // all beats taken, all results in, then release the output stall to clear the pipe
  task automatic wait_idle();
    @(negedge clk_i);
    while (beats_taken != beats_pushed || grad_expected.size() != 0) @(negedge clk_i);
    settle <= 1'b1;
    repeat (SETTLE_TICKS) @(negedge clk_i);
    settle <= 1'b0;
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w_word, input logic [CFG_W-1:0] h_word);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_FRAME_WIDTH;
    cfg_wdata_i <= w_word;
    fw_reg = w_word[FW_W-1:0];
    @(negedge clk_i);
    cfg_idx_i   <= CFG_FRAME_HEIGHT;
    cfg_wdata_i <= h_word;
    fh_reg = h_word[FH_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_frame(input logic [CFG_W-1:0] w_word, input logic [CFG_W-1:0] h_word,
                            input bit binary, input bit pause_mid, input bit reconf);
    int unsigned w, h, n, p, d;
    if (reconf) begin
      wait_idle();
      set_frame(w_word, h_word);
    end
    w = eff_width(fw_reg);
    h = eff_height(fh_reg);
    n = w * h;
    for (p = 0; p < n; p++) begin
      if ($urandom_range(0, 99) < 4) push_beat(CMD_FLUSH, PIX_W'($urandom_range(0, 255)));
      if (pause_mid && p == n / 2) wait_idle();
      if (binary) push_beat(CMD_PIXEL, ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00);
      else push_beat(CMD_PIXEL, PIX_W'($urandom_range(0, 255)));
    end
    // drain; a pixel here only stands in for a flush
    for (d = 0; d <= w; d++) begin
      if ($urandom_range(0, 99) < 20) push_beat(CMD_PIXEL, PIX_W'($urandom_range(0, 255)));
      else push_beat(CMD_FLUSH, PIX_W'($urandom_range(0, 255)));
    end
    repeat ($urandom_range(0, 2)) push_beat(CMD_FLUSH, PIX_W'($urandom_range(0, 255)));
    counted += n + w + 1;
  endtask

  task automatic random_frame();
    logic [CFG_W-1:0] w_word, h_word;
    int unsigned      pick;
    bit               reconf;
    pick = $urandom_range(0, 99);
    if (pick < 5) w_word = '0;
    else if (pick < 15) w_word = CFG_W'($urandom_range(13, 48));
    else w_word = CFG_W'($urandom_range(1, 12));
    pick = $urandom_range(0, 99);
    if (pick < 5) h_word = '0;
    else if (w_word > 12) h_word = CFG_W'($urandom_range(1, 3));
    else if (pick < 12) h_word = CFG_W'($urandom_range(9, 20));
    else h_word = CFG_W'($urandom_range(1, 8));
    reconf = $urandom_range(0, 1) != 0 || eff_width(fw_reg) * eff_height(fh_reg) > 600;
    send_frame(w_word, h_word, $urandom_range(0, 2) == 0, $urandom_range(0, 4) == 0, reconf);
  endtask

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    int unsigned start;
    foreach (line_up1[i]) begin
      line_up1[i] = '0;
      line_up2[i] = '0;
    end
    foreach (win[r, c]) win[r][c] = '0;
    col_in  = 0;
    row_in  = 0;
    col_out = 0;
    row_out = 0;

    repeat (5) @(negedge clk_i);
    rst_ni      <= 1'b1;
    tx_idle_pct <= 25;
    rx_idle_pct <= 53;

    // 4x3 with columns dark, bright, bright, dark: both gx extremes;
    // a flush mid-frame, a pixel in the drain and a flush after the end
    wait_idle();
    set_frame(12'd4, 12'd3);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (r == 1 && c == 1) push_beat(CMD_FLUSH, 8'h3C);
        push_beat(CMD_PIXEL, (c == 1 || c == 2) ? 8'hFF : 8'h00);
      end
    end
    for (int d = 0; d < 5; d++) begin
      if (d == 2) push_beat(CMD_PIXEL, 8'hA5);
      else push_beat(CMD_FLUSH, 8'h00);
    end
    push_beat(CMD_FLUSH, 8'hFF);

    // zero width and height act as a single pixel frame
    wait_idle();
    set_frame(12'd0, 12'd0);
    push_beat(CMD_PIXEL, 8'hFF);
    push_beat(CMD_FLUSH, 8'h00);
    push_beat(CMD_PIXEL, 8'h5A);
    push_beat(CMD_FLUSH, 8'h81);

    start = counted;
    while (counted - start < 500) random_frame();

    wait_idle();
    tx_idle_pct <= 53;
    rx_idle_pct <= 25;
    start = counted;
    while (counted - start < 470) random_frame();
    send_frame(12'd2, 12'd40, 1'b1, 1'b1, 1'b1);

    wait_idle();
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    start = counted;
    while (counted - start < 500) random_frame();

    wait_idle();
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
